/* design/plht_pkg.sv */
// ----------------------------------------------------------------------------
// plht_pkg
// Shared types and constants of the page lookup hash table: field widths,
// request and result codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package plht_pkg;

  localparam int PLHT_BUCKETS = 16;
  localparam int PLHT_ENTRIES = 64;

  localparam int REQ_W   = 2;
  localparam int FID_W   = 16;
  localparam int PAGE_W  = 24;
  localparam int SLOT_W  = 8;
  localparam int RES_W   = 2;
  localparam int KEY_W   = FID_W + PAGE_W;

  // bucket hash: the 25-bit key sum is reduced a few bits per cycle
  localparam int HASH_STEP = 5;
  localparam int HASH_SUMW = PAGE_W + 1;
  localparam int HASH_CYC  = (HASH_SUMW + HASH_STEP - 1) / HASH_STEP;
  localparam int HASH_PW   = HASH_CYC * HASH_STEP;
  localparam int HCNT_W    = (HASH_CYC > 1) ? $clog2(HASH_CYC) : 1;

  // free entry search: one group of valid bits per cycle
  localparam int SCAN_GW = 32;
  localparam int SCAN_IW = $clog2(SCAN_GW);

  typedef enum logic [REQ_W-1:0] {
    REQ_FIND   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2
  } req_t;

  typedef enum logic [RES_W-1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_EXISTS    = 2'd2,
    RES_FULL      = 2'd3
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_WALK,
    ST_SCAN,
    ST_INSERT,
    ST_DELETE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic clr_wr;
    logic head_rd;
    logic walk_start;
    logic walk_next;
    logic scan_step;
    logic ins_wr;
    logic del_wr;
    logic resp_load;
    res_t resp_code;
    logic resp_slot;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic head_null;
    logic key_match;
    logic walk_end;
    logic scan_found;
    logic scan_last;
    logic out_free;
    req_t req;
  } sts_t;

endpackage

/* design/plht_ram.sv */
// ----------------------------------------------------------------------------
// plht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module plht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/plht_ctrl.sv */
// ----------------------------------------------------------------------------
// plht_ctrl
// Request sequencer: clearing pass, hashing, chain walk, free entry search,
// table update and result hand-off.
// ----------------------------------------------------------------------------
module plht_ctrl import plht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  res_t   rcode, rcode_next;
  logic   rslot, rslot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      rcode <= RES_OK;
      rslot <= 1'b0;
    end else begin
      state <= state_next;
      rcode <= rcode_next;
      rslot <= rslot_next;
    end
  end

  always_comb begin
    state_next = state;
    rcode_next = rcode;
    rslot_next = rslot;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_HASH;
      end
      ST_HASH: begin
        if (sts.hash_last) state_next = ST_HEAD_RD;
      end
      ST_HEAD_RD: begin
        state_next = ST_HEAD_CHK;
      end
      ST_HEAD_CHK: begin
        rslot_next = 1'b0;
        case (sts.req)
          REQ_FIND, REQ_DELETE: begin
            if (sts.head_null) begin
              state_next = ST_RESP;
              rcode_next = RES_NOT_FOUND;
            end else begin
              state_next = ST_WALK;
            end
          end
          REQ_INSERT: begin
            state_next = sts.head_null ? ST_SCAN : ST_WALK;
          end
          default: begin
            state_next = ST_RESP;
            rcode_next = RES_NOT_FOUND;
          end
        endcase
      end
      ST_WALK: begin
        if (sts.key_match) begin
          case (sts.req)
            REQ_FIND: begin
              state_next = ST_RESP;
              rcode_next = RES_OK;
              rslot_next = 1'b1;
            end
            REQ_INSERT: begin
              state_next = ST_RESP;
              rcode_next = RES_EXISTS;
            end
            REQ_DELETE: begin
              state_next = ST_DELETE;
              rcode_next = RES_OK;
            end
            default: begin
              state_next = ST_RESP;
              rcode_next = RES_NOT_FOUND;
            end
          endcase
        end else if (sts.walk_end) begin
          if (sts.req == REQ_INSERT) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESP;
            rcode_next = RES_NOT_FOUND;
          end
        end
      end
      ST_SCAN: begin
        if (sts.scan_found) begin
          state_next = ST_INSERT;
          rcode_next = RES_OK;
        end else if (sts.scan_last) begin
          state_next = ST_RESP;
          rcode_next = RES_FULL;
        end
      end
      ST_INSERT, ST_DELETE: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_HASH:     cmd.hash_step = 1'b1;
      ST_HEAD_RD:  cmd.head_rd = 1'b1;
      ST_HEAD_CHK: cmd.walk_start = 1'b1;
      ST_WALK:     cmd.walk_next = !sts.key_match && !sts.walk_end;
      ST_SCAN:     cmd.scan_step = 1'b1;
      ST_INSERT:   cmd.ins_wr = 1'b1;
      ST_DELETE:   cmd.del_wr = 1'b1;
      ST_RESP: begin
        cmd.resp_load = sts.out_free;
        cmd.resp_code = rcode;
        cmd.resp_slot = rslot;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* design/plht_dp.sv */
// ----------------------------------------------------------------------------
// plht_dp
// Datapath: request registers, bucket hash reducer, bucket head and entry
// memories, chain walk registers, entry valid map with free entry search,
// and the result register.
// ----------------------------------------------------------------------------
module plht_dp import plht_pkg::*; #(
  parameter int BUCKETS = PLHT_BUCKETS,
  parameter int ENTRIES = PLHT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [FID_W-1:0]  file_id,
  input  logic [PAGE_W-1:0] page_number,
  input  logic [SLOT_W-1:0] slot_value,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RES_W-1:0]  status,
  output logic [SLOT_W-1:0] slot_found
);

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EW  = $clog2(ENTRIES + 1);
  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW  = $clog2(BUCKETS + 1);
  localparam int DW  = KEY_W + SLOT_W + EW;
  localparam int NG  = (ENTRIES + SCAN_GW - 1) / SCAN_GW;
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [EW-1:0] NIL = EW'(ENTRIES);
  localparam logic [RW:0]   BK  = (RW + 1)'(BUCKETS);

  req_t               req;
  logic [KEY_W-1:0]   key;
  logic [SLOT_W-1:0]  slot;
  logic [HASH_PW-1:0] sh;
  logic [RW-1:0]      rem, rem_next;
  logic [HCNT_W-1:0]  hcnt;
  logic [BW-1:0]      clr_cnt;
  logic [EW-1:0]      head_q, cur, prv, steps;
  logic [DW-1:0]      prv_rec;
  logic [GIW-1:0]     scan_g;
  logic [IW-1:0]      free_idx;
  logic [ENTRIES-1:0] valid;
  res_t               out_status;
  logic [SLOT_W-1:0]  out_slot;

  logic [BW-1:0]      bucket;
  logic [EW-1:0]      head_rdata;
  logic [DW-1:0]      rec;
  logic [KEY_W-1:0]   rec_key;
  logic [SLOT_W-1:0]  rec_slot;
  logic [EW-1:0]      rec_link;
  logic               h_we, e_we, e_re;
  logic [BW-1:0]      h_waddr;
  logic [EW-1:0]      h_wdata;
  logic [IW-1:0]      e_waddr, e_raddr;
  logic [DW-1:0]      e_wdata;
  logic [NG*SCAN_GW-1:0] vpad;
  logic [SCAN_GW-1:0] grp;
  logic [SCAN_IW-1:0] pos;
  logic               found;

  assign bucket   = rem[BW-1:0];
  assign rec_key  = rec[DW-1 -: KEY_W];
  assign rec_slot = rec[EW +: SLOT_W];
  assign rec_link = rec[EW-1:0];

  // reduce the key sum modulo the bucket count, one bit per step
  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] r;
    r = rem;
    t = '0;
    for (int k = 0; k < HASH_STEP; k++) begin
      t = {r, sh[HASH_PW-1-k]};
      if (t >= BK) t = t - BK;
      r = t[RW-1:0];
    end
    rem_next = r;
  end

  // pad the valid map with busy entries up to whole search groups
  for (genvar i = 0; i < NG * SCAN_GW; i++) begin : g_vpad
    if (i < ENTRIES) begin : g_real
      assign vpad[i] = valid[i];
    end else begin : g_pad
      assign vpad[i] = 1'b1;
    end
  end

  assign grp = vpad[scan_g * SCAN_GW +: SCAN_GW];

  always_comb begin
    pos   = '0;
    found = 1'b0;
    for (int i = SCAN_GW - 1; i >= 0; i--) begin
      if (!grp[i]) begin
        pos   = SCAN_IW'(i);
        found = 1'b1;
      end
    end
  end

  // memory port selection
  always_comb begin
    h_we    = 1'b0;
    h_waddr = clr_cnt;
    h_wdata = NIL;
    e_we    = 1'b0;
    e_waddr = free_idx;
    e_wdata = {key, slot, head_q};
    if (cmd.clr_wr) begin
      h_we = 1'b1;
    end
    if (cmd.ins_wr) begin
      h_we    = 1'b1;
      h_waddr = bucket;
      h_wdata = EW'(free_idx);
      e_we    = 1'b1;
    end
    if (cmd.del_wr) begin
      if (prv == NIL) begin
        h_we    = 1'b1;
        h_waddr = bucket;
        h_wdata = rec_link;
      end else begin
        e_we    = 1'b1;
        e_waddr = prv[IW-1:0];
        e_wdata = {prv_rec[DW-1:EW], rec_link};
      end
    end
  end

  assign e_re    = cmd.walk_start || cmd.walk_next;
  assign e_raddr = cmd.walk_start ? head_rdata[IW-1:0] : rec_link[IW-1:0];

  plht_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (cmd.head_rd),
    .raddr (bucket),
    .rdata (head_rdata)
  );

  plht_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (rec)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.ins_wr) valid[free_idx] <= 1'b1;
      if (cmd.del_wr) valid[cur[IW-1:0]] <= 1'b0;
      if (cmd.resp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= req_t'(req_type);
      key  <= {file_id, page_number};
      slot <= slot_value;
      sh   <= HASH_PW'(file_id) + HASH_PW'(page_number);
      rem  <= '0;
      hcnt <= '0;
    end
    if (cmd.hash_step) begin
      rem  <= rem_next;
      sh   <= sh << HASH_STEP;
      hcnt <= hcnt + 1'b1;
    end
    if (cmd.walk_start) begin
      head_q <= head_rdata;
      cur    <= head_rdata;
      prv    <= NIL;
      steps  <= '0;
      scan_g <= '0;
    end
    if (cmd.walk_next) begin
      prv     <= cur;
      prv_rec <= rec;
      cur     <= rec_link;
      steps   <= steps + 1'b1;
    end
    if (cmd.scan_step) begin
      if (found) begin
        free_idx <= IW'({scan_g, pos});
      end else begin
        scan_g <= scan_g + 1'b1;
      end
    end
    if (cmd.resp_load) begin
      out_status <= cmd.resp_code;
      out_slot   <= cmd.resp_slot ? rec_slot : '0;
    end
  end

  always_comb begin
    sts.clr_last   = (clr_cnt == BW'(BUCKETS - 1));
    sts.hash_last  = (hcnt == HCNT_W'(HASH_CYC - 1));
    sts.head_null  = (head_rdata >= NIL);
    sts.key_match  = (rec_key == key);
    sts.walk_end   = (rec_link >= NIL) || (steps == EW'(ENTRIES - 1));
    sts.scan_found = found;
    sts.scan_last  = (scan_g == GIW'(NG - 1));
    sts.out_free   = !out_valid || out_ready;
    sts.req        = req;
  end

  assign status     = out_status;
  assign slot_found = out_slot;

endmodule

/* design/page_lookup_hash_table_core.sv */
// ----------------------------------------------------------------------------
// page_lookup_hash_table_core
// Chained hash map from (file id, page number) to a buffer slot.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. A request is
// accepted (ST_IDLE), its key sum is reduced to a bucket index (ST_HASH),
// the bucket head is read (ST_HEAD_RD, ST_HEAD_CHK), then the chain is walked
// one entry at a time (the entry memory read port is the loop), and the result
// is handed to the output register (ST_RESP). An insert of a new key adds a
// free entry search over up to ceil(ENTRIES/32) groups of valid bits plus a
// table write; a delete that hits adds a table write. After reset every
// bucket head is set to the empty link before the first request is taken.
// The output register lets a result wait while the next request is accepted.
// ----------------------------------------------------------------------------
module page_lookup_hash_table_core import plht_pkg::*; #(
  parameter int BUCKETS = PLHT_BUCKETS,
  parameter int ENTRIES = PLHT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [FID_W-1:0]  file_id,
  input  logic [PAGE_W-1:0] page_number,
  input  logic [SLOT_W-1:0] slot_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RES_W-1:0]  status,
  output logic [SLOT_W-1:0] slot_found
);

  cmd_t cmd;
  sts_t sts;

  plht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plht_dp #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .file_id     (file_id),
    .page_number (page_number),
    .slot_value  (slot_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot_found  (slot_found)
  );

  // never overwrite a result still waiting at the output
  a_resp_free: assert property (@(posedge clk) disable iff (rst)
    cmd.resp_load |-> sts.out_free)
    else $error("result loaded over a pending result");

  // accept a request only when no table write is under way
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(cmd.ins_wr || cmd.del_wr || cmd.clr_wr))
    else $error("request accepted during a table write");

  // insert writes only a free entry found by the search
  a_ins_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |-> $past(cmd.scan_step && sts.scan_found))
    else $error("insert without a free entry");

  // delete only unlinks a matching entry
  a_del_after_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.del_wr |-> $past(sts.key_match))
    else $error("delete without a key match");

endmodule
